// ----- rtl/core/tcma_pkg.sv -----
// Shared constants, types and register codes of the three-axis calibrated moving average.
`default_nettype none

package tcma_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

  localparam int WIN_W      = 7;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = 3 * COEF_W;
  localparam int OFS_W      = 20;
  localparam int OFS_ALL_W  = 3 * OFS_W;
  localparam int OUT_W      = 24;
  localparam int CFG_DATA_W = 60;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 12;

  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SHF_W  = ACC_W - FRAC_BITS;
  localparam int RES_W0 = (SHF_W > OFS_W) ? SHF_W : OFS_W;
  localparam int RES_W  = ((RES_W0 > OUT_W) ? RES_W0 : OUT_W) + 1;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ROW_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ROW_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ROW_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TRIPLE = 3'd4;

  localparam logic [WIN_W-1:0]  WINDOW_RST = 7'd50;
  localparam logic [COEF_W-1:0] COEF_ONE   = 16'd4096;
  localparam logic [ROW_W-1:0]  ROW_X_RST  = {16'd0, 16'd0, COEF_ONE};
  localparam logic [ROW_W-1:0]  ROW_Y_RST  = {16'd0, COEF_ONE, 16'd0};
  localparam logic [ROW_W-1:0]  ROW_Z_RST  = {COEF_ONE, 16'd0, 16'd0};
  localparam logic [OFS_W-1:0]  OFS_X_RST  = 20'(-350);
  localparam logic [OFS_W-1:0]  OFS_Y_RST  = 20'(-2050);
  localparam logic [OFS_W-1:0]  OFS_Z_RST  = 20'(650);
  localparam logic [OFS_ALL_W-1:0] OFS_RST = {OFS_Z_RST, OFS_Y_RST, OFS_X_RST};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] z;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] x;
  } sample_t;

  typedef struct packed {
    logic                        start;
    logic [CNT_W-1:0]            divisor;
    logic [2:0][SUM_W-1:0]       sums;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic [2:0][SAMPLE_BITS-1:0] avg;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcma_front.sv -----
// Front end: accepts input transactions into a short queue ahead of the processing back end.
`default_nettype none

module tcma_front import tcma_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_z,
  output logic                               q_valid,
  output sample_t                            q_sample,
  input  wire logic                          q_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  sample_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                push;

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_sample = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= '{x: in_sample_x, y: in_sample_y, z: in_sample_z};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcma_div.sv -----
// Three-lane restoring divider that turns the window sums into truncated averages.
`default_nettype none

module tcma_div import tcma_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  d_r;
  logic [SUM_W-1:0]  dq_r  [3];
  logic [CNT_W-1:0]  rem_r [3];
  logic              neg_r [3];

  logic [CNT_W:0]    trial   [3];
  logic              ge      [3];
  logic [CNT_W-1:0]  rem_nxt [3];
  logic [SUM_W-1:0]  dq_nxt  [3];
  logic [SUM_W-1:0]  mag     [3];
  logic [SUM_W-1:0]  quo     [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l]   = {rem_r[l], dq_r[l][SUM_W-1]};
      ge[l]      = (trial[l] >= {1'b0, d_r});
      rem_nxt[l] = ge[l] ? CNT_W'(trial[l] - {1'b0, d_r}) : CNT_W'(trial[l]);
      dq_nxt[l]  = {dq_r[l][SUM_W-2:0], ge[l]};
      mag[l]     = req.sums[l][SUM_W-1] ? (~req.sums[l] + 1'b1) : req.sums[l];
      quo[l]     = neg_r[l] ? (~dq_r[l] + 1'b1) : dq_r[l];
      rsp.avg[l] = quo[l][SAMPLE_BITS-1:0];
    end
    rsp.done = done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == STEP_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      d_r <= req.divisor;
      for (int l = 0; l < 3; l++) begin
        dq_r[l]  <= mag[l];
        rem_r[l] <= '0;
        neg_r[l] <= req.sums[l][SUM_W-1];
      end
    end else if (busy_r) begin
      for (int l = 0; l < 3; l++) begin
        dq_r[l]  <= dq_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcma_back.sv -----
// Back end: sample ring, window sums, averaging, calibration and the output register.
`default_nettype none

module tcma_back import tcma_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     q_valid,
  input  wire sample_t                  q_sample,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [OUT_W-1:0]       out_rate_x,
  output logic signed [OUT_W-1:0]       out_rate_y,
  output logic signed [OUT_W-1:0]       out_rate_z
);

  localparam int CMP_W = (WIN_W > CNT_W) ? WIN_W : CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_DSTART, S_DWAIT, S_MUL, S_OUT
  } state_t;

  state_t                    state_r;
  logic [WIN_W-1:0]          win_r;
  logic [2:0][ROW_W-1:0]     coef_rows_r;
  logic [OFS_ALL_W-1:0]      ofs_r;

  sample_t                   ring_r [MAX_WINDOW];
  sample_t                   rd_data_r;
  logic [PTR_W-1:0]          wp_r;
  logic [PTR_W-1:0]          idx_r;
  logic [CNT_W-1:0]          fill_r;
  logic [CNT_W-1:0]          n_r;
  logic [CNT_W-1:0]          rem_cnt_r;
  logic                      pend_r;
  logic signed [SUM_W-1:0]   sum_x_r;
  logic signed [SUM_W-1:0]   sum_y_r;
  logic signed [SUM_W-1:0]   sum_z_r;

  logic [2:0][SAMPLE_BITS-1:0] avg_r;
  logic [1:0]                mrow_r;
  logic [1:0]                mcol_r;
  logic                      issue_done_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      mul_v_r;
  logic                      mul_first_r;
  logic                      mul_last_r;
  logic [1:0]                mul_row_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   fin_acc_r;
  logic                      fin_v_r;
  logic [1:0]                fin_row_r;
  logic [2:0][OUT_W-1:0]     res_r;

  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_rate_x_r;
  logic signed [OUT_W-1:0]   out_rate_y_r;
  logic signed [OUT_W-1:0]   out_rate_z_r;

  logic [CNT_W-1:0]          fill_nxt;
  logic [CMP_W-1:0]          win_ext;
  logic [CMP_W-1:0]          win_c;
  logic [CMP_W-1:0]          fill_ext;
  logic [CNT_W-1:0]          n_c;
  logic                      rd_en;
  logic                      issue;
  logic [COEF_W-1:0]         coef_sel;
  logic [SAMPLE_BITS-1:0]    avg_sel;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic [OFS_W-1:0]          ofs_sel;
  logic signed [SHF_W-1:0]   shf;
  logic signed [RES_W-1:0]   res_sum;
  logic [OUT_W-1:0]          res_sat;
  logic                      out_load;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  always_comb begin
    fill_nxt = (fill_r < CNT_W'(MAX_WINDOW)) ? fill_r + 1'b1 : fill_r;
    win_ext  = CMP_W'(win_r);
    if (win_ext == '0) begin
      win_c = CMP_W'(1);
    end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
      win_c = CMP_W'(MAX_WINDOW);
    end else begin
      win_c = win_ext;
    end
    fill_ext = CMP_W'(fill_nxt);
    n_c      = CNT_W'((fill_ext < win_c) ? fill_ext : win_c);
  end

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign rd_en    = (state_r == S_SUM) && (rem_cnt_r != '0);
  assign issue    = (state_r == S_MUL) && !issue_done_r;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    div_req.start   = (state_r == S_DSTART);
    div_req.divisor = n_r;
    div_req.sums    = {sum_z_r, sum_y_r, sum_x_r};
  end

  tcma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    case (mcol_r)
      2'd0: begin
        coef_sel = coef_rows_r[mrow_r][COEF_W-1:0];
        avg_sel  = avg_r[0];
      end
      2'd1: begin
        coef_sel = coef_rows_r[mrow_r][2*COEF_W-1:COEF_W];
        avg_sel  = avg_r[1];
      end
      2'd2: begin
        coef_sel = coef_rows_r[mrow_r][3*COEF_W-1:2*COEF_W];
        avg_sel  = avg_r[2];
      end
      default: begin
        coef_sel = '0;
        avg_sel  = '0;
      end
    endcase
    acc_nxt = (mul_first_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
    case (fin_row_r)
      2'd0:    ofs_sel = ofs_r[OFS_W-1:0];
      2'd1:    ofs_sel = ofs_r[2*OFS_W-1:OFS_W];
      2'd2:    ofs_sel = ofs_r[3*OFS_W-1:2*OFS_W];
      default: ofs_sel = '0;
    endcase
    shf     = fin_acc_r[ACC_W-1:FRAC_BITS];
    res_sum = RES_W'(shf) + RES_W'($signed(ofs_sel));
    if (res_sum > RES_W'(OUT_MAX)) begin
      res_sat = OUT_W'(OUT_MAX);
    end else if (res_sum < RES_W'(OUT_MIN)) begin
      res_sat = OUT_W'(OUT_MIN);
    end else begin
      res_sat = res_sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ring_r[wp_r] <= q_sample;
    end
    if (rd_en) begin
      rd_data_r <= ring_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_r        <= WINDOW_RST;
      coef_rows_r  <= {ROW_Z_RST, ROW_Y_RST, ROW_X_RST};
      ofs_r        <= OFS_RST;
      wp_r         <= '0;
      idx_r        <= '0;
      fill_r       <= '0;
      n_r          <= '0;
      rem_cnt_r    <= '0;
      pend_r       <= 1'b0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      sum_z_r      <= '0;
      mrow_r       <= '0;
      mcol_r       <= '0;
      issue_done_r <= 1'b1;
      mul_v_r      <= 1'b0;
      fin_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: win_r          <= cfg_data[WIN_W-1:0];
          CFG_COEFF_ROW_X:   coef_rows_r[0] <= cfg_data[ROW_W-1:0];
          CFG_COEFF_ROW_Y:   coef_rows_r[1] <= cfg_data[ROW_W-1:0];
          CFG_COEFF_ROW_Z:   coef_rows_r[2] <= cfg_data[ROW_W-1:0];
          CFG_OFFSET_TRIPLE: ofs_r          <= cfg_data[OFS_ALL_W-1:0];
          default:           ;
        endcase
      end

      pend_r <= rd_en;
      if (pend_r) begin
        sum_x_r <= sum_x_r + SUM_W'(rd_data_r.x);
        sum_y_r <= sum_y_r + SUM_W'(rd_data_r.y);
        sum_z_r <= sum_z_r + SUM_W'(rd_data_r.z);
      end

      mul_v_r <= issue;
      if (issue) begin
        prod_r      <= $signed(coef_sel) * $signed(avg_sel);
        mul_first_r <= (mcol_r == 2'd0);
        mul_last_r  <= (mcol_r == 2'd2);
        mul_row_r   <= mrow_r;
        if (mcol_r == 2'd2) begin
          mcol_r <= 2'd0;
          mrow_r <= mrow_r + 1'b1;
          if (mrow_r == 2'd2) begin
            issue_done_r <= 1'b1;
          end
        end else begin
          mcol_r <= mcol_r + 1'b1;
        end
      end
      fin_v_r <= mul_v_r && mul_last_r;
      if (mul_v_r) begin
        acc_r <= acc_nxt;
        if (mul_last_r) begin
          fin_acc_r <= acc_nxt;
          fin_row_r <= mul_row_r;
        end
      end
      if (fin_v_r) begin
        res_r[fin_row_r] <= res_sat;
      end

      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            wp_r      <= (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
            idx_r     <= wp_r;
            fill_r    <= fill_nxt;
            n_r       <= n_c;
            rem_cnt_r <= n_c;
            sum_x_r   <= '0;
            sum_y_r   <= '0;
            sum_z_r   <= '0;
            state_r   <= S_SUM;
          end
        end
        S_SUM: begin
          if (rd_en) begin
            rem_cnt_r <= rem_cnt_r - 1'b1;
            idx_r     <= (idx_r == '0) ? PTR_W'(MAX_WINDOW - 1) : idx_r - 1'b1;
          end else begin
            state_r <= S_DSTART;
          end
        end
        S_DSTART: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            avg_r        <= div_rsp.avg;
            mrow_r       <= '0;
            mcol_r       <= '0;
            issue_done_r <= 1'b0;
            state_r      <= S_MUL;
          end
        end
        S_MUL: begin
          if (fin_v_r && (fin_row_r == 2'd2)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_x_r <= res_r[0];
      out_rate_y_r <= res_r[1];
      out_rate_z_r <= res_r[2];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rate_x = out_rate_x_r;
  assign out_rate_y = out_rate_y_r;
  assign out_rate_z = out_rate_z_r;

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DWAIT))
    else $error("divider finished outside its wait state");

  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (n_r != '0) && (n_r <= fill_r) &&
                           (fill_r <= CNT_W'(MAX_WINDOW)))
    else $error("averaging count outside the filled part of the ring");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("new result overran an unaccepted one");

  a_final_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r |-> (state_r == S_MUL))
    else $error("calibration result produced outside the multiply phase");

endmodule

`default_nettype wire

// ----- rtl/core/three_axis_calibrated_moving_average.sv -----
// Top level of the three-axis calibrated moving average.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  in_sample_x, in_sample_y, in_sample_z
//   out_      output     out_valid/out_stall  out_rate_x, out_rate_y, out_rate_z
//   cfg_      input      cfg_we               cfg_index, cfg_data
//
// In each transaction the ring memory gives the n samples averaged to the sums, one sample per
// cycle, and the divider resolves one quotient bit per cycle for all three axes at once.
// Reset is synchronous and active low; it empties the ring, the queue and the output register.
// A two-entry input queue keeps accepting, until it is full, while the back end works or its result waits.
`default_nettype none

module three_axis_calibrated_moving_average import tcma_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [OUT_W-1:0]            out_rate_x,
  output logic signed [OUT_W-1:0]            out_rate_y,
  output logic signed [OUT_W-1:0]            out_rate_z,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  logic    q_valid;
  logic    q_pop;
  sample_t q_sample;

  tcma_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample_x (in_sample_x),
    .in_sample_y (in_sample_y),
    .in_sample_z (in_sample_z),
    .q_valid     (q_valid),
    .q_sample    (q_sample),
    .q_pop       (q_pop)
  );

  tcma_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_sample   (q_sample),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rate_x (out_rate_x),
    .out_rate_y (out_rate_y),
    .out_rate_z (out_rate_z)
  );

endmodule

`default_nettype wire
